// ===== hw/rtl/bma_pkg.sv =====
// bma_pkg: shared types, constants and helpers of the bitmap allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

    localparam int MAX_BITS_DEFAULT = 1024;
    localparam int BIU_W            = 11;
    localparam int IDX_W            = 10;
    localparam int BYTE_W           = 8;
    localparam int BIU_RESET        = 1024;
    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TEST  = 2'd2,
        OP_ALLOC = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_HOLD
    } state_t;

    // position of the lowest zero bit of a byte
    function automatic logic [2:0] first_zero(input logic [BYTE_W-1:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            if (!b[k])
            begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bma_req_if.sv =====
// bma_req_if: request channel of the bitmap allocator
// depends on bma_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bma_req_if;
    logic                          valid;
    logic                          ready;
    bma_pkg::op_t                  operation;
    logic [bma_pkg::IDX_W-1:0]     bit_index;

    modport source (output valid, output operation, output bit_index, input ready);
    modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bma_rsp_if.sv =====
// bma_rsp_if: response channel of the bitmap allocator
// depends on bma_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bma_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          bit_value;
    logic                          found;
    logic [bma_pkg::IDX_W-1:0]     alloc_index;
    bma_pkg::status_t              status;

    modport source (output valid, output bit_value, output found, output alloc_index,
                    output status, input ready);
    modport sink   (input valid, input bit_value, input found, input alloc_index,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bma_ram.sv =====
// bma_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bma_ctrl.sv =====
// bma_ctrl: sequencer of the bitmap allocator - clearing pass, read-modify-write,
// byte scan and result register; depends on bma_pkg, bma_req_if, bma_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module bma_ctrl #(
    parameter int MAX_BITS    = bma_pkg::MAX_BITS_DEFAULT,
    parameter int STORE_BYTES = (MAX_BITS + 7) / 8,
    parameter int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
    parameter int CNT_W       = $clog2(STORE_BYTES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [CNT_W-1:0]            nbytes,
    bma_req_if.sink                          req,
    bma_rsp_if.source                        rsp,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [bma_pkg::BYTE_W-1:0]       wr_data,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    input  wire logic [bma_pkg::BYTE_W-1:0]  rd_data
);
    import bma_pkg::*;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [2:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;

    logic                pend_bit_reg, pend_bit_next;
    logic                pend_found_reg, pend_found_next;
    logic [IDX_W-1:0]    pend_alloc_reg, pend_alloc_next;
    status_t             pend_status_reg, pend_status_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_bit_reg, out_bit_next;
    logic                out_found_reg, out_found_next;
    logic [IDX_W-1:0]    out_alloc_reg, out_alloc_next;
    status_t             out_status_reg, out_status_next;

    logic [6:0]          req_byte;
    logic                out_of_range;
    logic [CNT_W:0]      idx_plus;
    logic                scan_last;
    logic                slot_free;
    logic [BYTE_W-1:0]   mask;
    logic [2:0]          zero_pos;
    logic [AW+2:0]       alloc_full;

    assign req_byte     = req.bit_index[IDX_W-1:3];
    assign out_of_range = ({{CNT_W{1'b0}}, req_byte} >= {{7{1'b0}}, nbytes});
    assign idx_plus     = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign scan_last    = (idx_plus >= {1'b0, nbytes});
    assign slot_free    = !out_valid_reg || rsp.ready;
    assign mask         = BYTE_W'(1) << pos_reg;
    assign zero_pos     = first_zero(rd_data);
    assign alloc_full   = {idx_reg[AW-1:0], zero_pos};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == CNT_W'(STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        state_next = (nbytes == '0) ? S_HOLD : S_SCAN;
                    end
                    else
                    begin
                        state_next = out_of_range ? S_HOLD : S_ACCESS;
                    end
                end
            end
            S_ACCESS:
            begin
                state_next = S_HOLD;
            end
            S_SCAN:
            begin
                if (rd_data != FULL_BYTE || scan_last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready        = (state_reg == S_IDLE);
        rd_en            = 1'b0;
        rd_addr          = idx_reg[AW-1:0];
        wr_en            = 1'b0;
        wr_addr          = idx_reg[AW-1:0];
        wr_data          = '0;
        op_next          = op_reg;
        pos_next         = pos_reg;
        idx_next         = idx_reg;
        pend_bit_next    = pend_bit_reg;
        pend_found_next  = pend_found_reg;
        pend_alloc_next  = pend_alloc_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_bit_next     = out_bit_reg;
        out_found_next   = out_found_reg;
        out_alloc_next   = out_alloc_reg;
        out_status_next  = out_status_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_plus[CNT_W-1:0];
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next          = req.operation;
                    pos_next         = req.bit_index[2:0];
                    pend_bit_next    = 1'b0;
                    pend_found_next  = 1'b0;
                    pend_alloc_next  = '0;
                    pend_status_next = STAT_OK;
                    if (req.operation == OP_ALLOC)
                    begin
                        idx_next = '0;
                        rd_addr  = '0;
                        rd_en    = (nbytes != '0);
                        if (nbytes == '0)
                        begin
                            pend_status_next = STAT_FULL;
                        end
                    end
                    else if (out_of_range)
                    begin
                        pend_status_next = STAT_RANGE;
                    end
                    else
                    begin
                        idx_next = CNT_W'(req_byte);
                        rd_addr  = AW'(req_byte);
                        rd_en    = 1'b1;
                    end
                end
            end
            S_ACCESS:
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data | mask;
                    end
                    OP_CLEAR:
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~mask;
                    end
                    default:
                    begin
                        pend_bit_next = |(rd_data & mask);
                    end
                endcase
            end
            S_SCAN:
            begin
                if (rd_data != FULL_BYTE)
                begin
                    wr_en           = 1'b1;
                    wr_data         = rd_data | (BYTE_W'(1) << zero_pos);
                    pend_found_next = 1'b1;
                    pend_alloc_next = IDX_W'(alloc_full);
                end
                else if (scan_last)
                begin
                    pend_status_next = STAT_FULL;
                end
                else
                begin
                    // next byte is read while this one is checked
                    rd_en    = 1'b1;
                    rd_addr  = idx_plus[AW-1:0];
                    idx_next = idx_plus[CNT_W-1:0];
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bit_next    = pend_bit_reg;
                    out_found_next  = pend_found_reg;
                    out_alloc_next  = pend_alloc_reg;
                    out_status_next = pend_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            op_reg        <= OP_SET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        pend_bit_reg    <= pend_bit_next;
        pend_found_reg  <= pend_found_next;
        pend_alloc_reg  <= pend_alloc_next;
        pend_status_reg <= pend_status_next;
        out_bit_reg     <= out_bit_next;
        out_found_reg   <= out_found_next;
        out_alloc_reg   <= out_alloc_next;
        out_status_reg  <= out_status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bit_value   = out_bit_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.alloc_index = out_alloc_reg;
    assign rsp.status      = out_status_reg;

`ifndef SYNTHESIS
    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("read and write of the same entry in one cycle");

    a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ({1'b0, idx_reg} < {1'b0, nbytes}))
        else $error("scan beyond bytes in use");

    a_access_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCESS) |=> (state_reg == S_HOLD))
        else $error("modify step did not hand over to the result stage");

    a_full_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STAT_FULL)) |->
        (!out_found_reg && (out_alloc_reg == '0)))
        else $error("no-free result carries an index");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_allocator_top.sv =====
// bitmap_allocator_top: bitmap allocator with bits-in-use register, sequencer and
// mark store; depends on bma_pkg, bma_req_if, bma_rsp_if, bma_ram, bma_ctrl
//
// usage
//   req carries operation (set, clear, test, allocate) and bit_index; a request
//   transfer happens when req.valid and req.ready are both high. every request
//   gives exactly one response transfer on rsp (bit_value, found, alloc_index,
//   status), in order.
//   set, clear and test do one read-modify-write of the mark store: the read is
//   issued on the request transfer, the access state sets, clears or tests the
//   bit, and the hold state passes the result on to the output register. an
//   out-of-range index goes straight to the hold state without a store access.
//   allocate reads the store one byte per cycle from the lowest until a byte with
//   a free bit or the last byte in use; the next request of any kind is taken only
//   once the response of the last one has moved into the output register.
//   cfg_we writes bits_in_use from cfg_wdata; write it only while idle.
//   after reset a clearing pass zeroes every byte of the store, with req.ready
//   low; configuration writes are taken meanwhile.
//   the response sits in an output register: a new request is taken while it
//   waits, and the block stalls only once the next response is ready too.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator_top #(
    parameter int MAX_BITS = bma_pkg::MAX_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bma_pkg::BIU_W-1:0] cfg_wdata,
    bma_req_if.sink                        req,
    bma_rsp_if.source                      rsp
);
    import bma_pkg::*;

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int RST_BYTES   = ((BIU_RESET + 7) / 8 > STORE_BYTES) ?
                                 STORE_BYTES : (BIU_RESET + 7) / 8;

    // bits in use kept as a byte count, rounded up and limited to the store
    logic [CNT_W-1:0]  nbytes_reg, nbytes_next;
    logic [BIU_W:0]    cfg_sum;
    logic [BIU_W-3:0]  cfg_bytes;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;

    assign cfg_sum   = {1'b0, cfg_wdata} + (BIU_W + 1)'(7);
    assign cfg_bytes = cfg_sum[BIU_W:3];

    always_comb
    begin
        nbytes_next = nbytes_reg;
        if (cfg_we)
        begin
            if (int'(cfg_bytes) > STORE_BYTES)
            begin
                nbytes_next = CNT_W'(STORE_BYTES);
            end
            else
            begin
                nbytes_next = CNT_W'(cfg_bytes);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbytes_reg <= CNT_W'(RST_BYTES);
        end
        else
        begin
            nbytes_reg <= nbytes_next;
        end
    end

    bma_ctrl #(
        .MAX_BITS    (MAX_BITS),
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .nbytes  (nbytes_reg),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bma_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_marks (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
